### src/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg - shared definitions for the piecewise linear interpolator
// Table sizing, item codes, status codes and divider control bundle.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int MAX_POINTS = 32;
	localparam int PTR_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int POINTS_W   = 6;
	localparam int COORD_W    = 32;
	localparam int ENTRY_W    = 2 * COORD_W;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int DIV_STEPS  = PROD_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
	localparam int SUM_W      = PROD_W + 2;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_POINTS);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_QUERY  = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOT_MONO = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

### src/pli_ram.sv
// ----------------------------------------------------------------------------
// pli_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pli_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/pli_div.sv
// ----------------------------------------------------------------------------
// pli_div - serial unsigned divider
// Restoring division, one quotient bit per cycle, 64-bit by 32-bit.
// ----------------------------------------------------------------------------
module pli_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [pli_pkg::PROD_W-1:0]          dividend,
	input  logic [pli_pkg::COORD_W-1:0]         divisor,
	output logic [pli_pkg::PROD_W-1:0]          quotient,
	output pli_pkg::div_ctl_t                   ctl
);

	logic [pli_pkg::PROD_W-1:0]    dvd_q;   // dividend in, quotient out
	logic [pli_pkg::COORD_W-1:0]   dsr_q;
	logic [pli_pkg::COORD_W-1:0]   rem_q;
	logic [pli_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [pli_pkg::COORD_W:0]     rem_sh;
	logic [pli_pkg::COORD_W:0]     rem_sub;
	logic                          q_bit;

	assign rem_sh  = {rem_q, dvd_q[pli_pkg::PROD_W-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign q_bit   = !rem_sub[pli_pkg::COORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// pulses the cycle after the last quotient bit is shifted in
			done_q <= !start && (cnt_q == pli_pkg::DIV_CNT_W'(1));
			if (start) begin
				cnt_q <= pli_pkg::DIV_CNT_W'(pli_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[pli_pkg::PROD_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[pli_pkg::COORD_W-1:0] : rem_sh[pli_pkg::COORD_W-1:0];
		end
	end

	assign quotient = dvd_q;
	assign ctl.busy = (cnt_q != '0);
	assign ctl.done = done_q;

endmodule

### src/piecewise_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_unit - breakpoint table with linear lookup
// Flow: append, clear, unused kinds and refused queries go from accept
//   straight to the output state; a query reads and walks up to 32
//   breakpoints, then runs the 64-step divider when it interpolates.
// Throughput: one item at a time, the next taken once the result is registered
//   out; the single RAM read port walk and the 64-step divider set it.
// Reset: count, order flags, sequencer and output valid clear; table is kept.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// item in
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          kind,
	input  logic signed [pli_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [pli_pkg::COORD_W-1:0]  coord_y,
	// item out
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pli_pkg::COORD_W-1:0]  value_y,
	output logic [1:0]                          status,
	output logic [pli_pkg::POINTS_W-1:0]        points_held
);

	// One-hot sequencer. RD primes the RAM read, CMP walks one point a
	// cycle with the next read already in flight, DIFF/MUL build the
	// dividend, DIV waits on the serial divider, SUM adds and saturates.
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_CMP  = 8'b0000_0100,
		S_DIFF = 8'b0000_1000,
		S_MUL  = 8'b0001_0000,
		S_DIV  = 8'b0010_0000,
		S_SUM  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t                               state_q;
	logic [pli_pkg::CNT_W-1:0]            count_q;
	logic                                 seen_dec_q;
	logic                                 seen_inc_q;
	logic signed [pli_pkg::COORD_W-1:0]   last_x_q;   // x of newest point
	logic [pli_pkg::CNT_W-1:0]            k_q;        // walk step, next read
	logic                                 have_left_q;
	logic signed [pli_pkg::COORD_W-1:0]   qx_q;
	logic signed [pli_pkg::COORD_W-1:0]   xl_q;
	logic signed [pli_pkg::COORD_W-1:0]   yl_q;
	logic signed [pli_pkg::COORD_W-1:0]   xr_q;
	logic signed [pli_pkg::COORD_W-1:0]   yr_q;
	logic [pli_pkg::COORD_W-1:0]          num_q;
	logic [pli_pkg::COORD_W-1:0]          den_q;
	logic [pli_pkg::COORD_W-1:0]          mag_q;
	logic                                 neg_q;
	logic signed [pli_pkg::COORD_W-1:0]   res_val_q;
	pli_pkg::status_t                     res_st_q;
	logic                                 out_valid_q;
	logic signed [pli_pkg::COORD_W-1:0]   value_y_q;
	pli_pkg::status_t                     status_q;
	logic [pli_pkg::POINTS_W-1:0]         points_q;

	logic                                 accept;
	pli_pkg::kind_t                       kind_in;
	logic                                 out_free;
	logic [pli_pkg::CNT_W-1:0]            idx_full;
	logic                                 ram_we;
	logic [pli_pkg::ENTRY_W-1:0]          ram_rdata;
	logic signed [pli_pkg::COORD_W-1:0]   rd_x;
	logic signed [pli_pkg::COORD_W-1:0]   rd_y;
	logic [pli_pkg::COORD_W:0]            num_w;
	logic [pli_pkg::COORD_W:0]            den_w;
	logic [pli_pkg::COORD_W:0]            dy_w;
	logic [pli_pkg::COORD_W:0]            mag_w;
	logic [pli_pkg::PROD_W-1:0]           prod;
	logic                                 div_start;
	logic [pli_pkg::PROD_W-1:0]           quot;
	pli_pkg::div_ctl_t                    div_ctl;
	logic signed [pli_pkg::SUM_W-1:0]     sum_w;
	logic                                 sum_ovf;
	logic signed [pli_pkg::COORD_W-1:0]   sum_sat;
	logic [31:0]                          count_ext;

	assign accept   = in_valid && !in_stall;
	assign kind_in  = pli_pkg::kind_t'(kind);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// Walk order: ascending tables from the front, descending from the back.
	assign idx_full = seen_dec_q ? (count_q - pli_pkg::CNT_ONE - k_q) : k_q;
	assign ram_we   = accept && (kind_in == pli_pkg::KIND_APPEND)
	                  && (count_q != pli_pkg::CNT_FULL);

	pli_ram #(
		.WIDTH (pli_pkg::ENTRY_W),
		.DEPTH (pli_pkg::MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[pli_pkg::PTR_W-1:0]),
		.wdata ({coord_x, coord_y}),
		.raddr (idx_full[pli_pkg::PTR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign rd_x = ram_rdata[pli_pkg::ENTRY_W-1:pli_pkg::COORD_W];
	assign rd_y = ram_rdata[pli_pkg::COORD_W-1:0];

	// Differences for the slope; all known positive except dy.
	assign num_w = {qx_q[pli_pkg::COORD_W-1], qx_q} - {xl_q[pli_pkg::COORD_W-1], xl_q};
	assign den_w = {xr_q[pli_pkg::COORD_W-1], xr_q} - {xl_q[pli_pkg::COORD_W-1], xl_q};
	assign dy_w  = {yr_q[pli_pkg::COORD_W-1], yr_q} - {yl_q[pli_pkg::COORD_W-1], yl_q};
	assign mag_w = dy_w[pli_pkg::COORD_W] ? (~dy_w + 1'b1) : dy_w;

	// Product goes straight into the divider's dividend register.
	assign prod      = num_q * mag_q;
	assign div_start = (state_q == S_MUL);

	pli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (den_q),
		.quotient (quot),
		.ctl      (div_ctl)
	);

	// yl +/- quotient, then clamp to 32 bits
	always_comb begin
		if (neg_q) begin
			sum_w = pli_pkg::SUM_W'(yl_q) - $signed({2'b00, quot});
		end else begin
			sum_w = pli_pkg::SUM_W'(yl_q) + $signed({2'b00, quot});
		end
	end

	assign sum_ovf = !((sum_w[pli_pkg::SUM_W-1:pli_pkg::COORD_W-1] == '0)
	                 || (sum_w[pli_pkg::SUM_W-1:pli_pkg::COORD_W-1] == '1));

	always_comb begin
		if (!sum_ovf) begin
			sum_sat = sum_w[pli_pkg::COORD_W-1:0];
		end else if (sum_w[pli_pkg::SUM_W-1]) begin
			sum_sat = {1'b1, {(pli_pkg::COORD_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(pli_pkg::COORD_W-1){1'b1}}};
		end
	end

	assign count_ext = 32'(count_q);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			seen_dec_q  <= 1'b0;
			seen_inc_q  <= 1'b0;
			k_q         <= '0;
			have_left_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						// only a query on a usable, non-empty table walks it
						if ((kind_in == pli_pkg::KIND_QUERY) && !(seen_dec_q && seen_inc_q)
						    && (count_q != '0)) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_OUT;
						end
						unique case (kind_in)
							pli_pkg::KIND_APPEND: begin
								if (count_q != pli_pkg::CNT_FULL) begin
									count_q <= count_q + 1'b1;
									if (count_q != '0) begin
										if (coord_x < last_x_q) seen_dec_q <= 1'b1;
										if (coord_x > last_x_q) seen_inc_q <= 1'b1;
									end
								end
							end
							pli_pkg::KIND_CLEAR: begin
								count_q    <= '0;
								seen_dec_q <= 1'b0;
								seen_inc_q <= 1'b0;
							end
							default: ;
						endcase
					end
					k_q         <= '0;
					have_left_q <= 1'b0;
				end
				S_RD: begin
					k_q     <= k_q + 1'b1;
					state_q <= S_CMP;
				end
				S_CMP: begin
					// ram_rdata holds the point at walk step k_q - 1
					if (qx_q == rd_x) begin
						state_q <= S_OUT;
					end else if (qx_q > rd_x) begin
						have_left_q <= 1'b1;
						if (k_q == count_q) begin
							state_q <= S_OUT;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else if (!have_left_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: state_q <= S_MUL;
				S_MUL:  state_q <= S_DIV;
				S_DIV: begin
					if (div_ctl.done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					qx_q      <= coord_x;
					res_val_q <= '0;
					priority if ((kind_in == pli_pkg::KIND_APPEND)
					             && (count_q == pli_pkg::CNT_FULL)) begin
						res_st_q <= pli_pkg::ST_FULL;
					end else if ((kind_in == pli_pkg::KIND_QUERY)
					             && seen_dec_q && seen_inc_q) begin
						res_st_q <= pli_pkg::ST_NOT_MONO;
					end else if ((kind_in == pli_pkg::KIND_QUERY) && (count_q == '0)) begin
						res_st_q <= pli_pkg::ST_RANGE;
					end else begin
						res_st_q <= pli_pkg::ST_OK;
					end
					if ((kind_in == pli_pkg::KIND_APPEND) && (count_q != pli_pkg::CNT_FULL)) begin
						last_x_q <= coord_x;
					end
				end
			end
			S_CMP: begin
				if (qx_q == rd_x) begin
					res_val_q <= rd_y;
				end else if (qx_q > rd_x) begin
					xl_q <= rd_x;
					yl_q <= rd_y;
					if (k_q == count_q) begin
						res_st_q <= pli_pkg::ST_RANGE;
					end
				end else if (!have_left_q) begin
					res_st_q <= pli_pkg::ST_RANGE;
				end else begin
					xr_q <= rd_x;
					yr_q <= rd_y;
				end
			end
			S_DIFF: begin
				num_q <= num_w[pli_pkg::COORD_W-1:0];
				den_q <= den_w[pli_pkg::COORD_W-1:0];
				mag_q <= mag_w[pli_pkg::COORD_W-1:0];
				neg_q <= dy_w[pli_pkg::COORD_W];
			end
			S_SUM: res_val_q <= sum_sat;
			S_OUT: begin
				if (out_free) begin
					value_y_q <= res_val_q;
					status_q  <= res_st_q;
					points_q  <= count_ext[pli_pkg::POINTS_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign value_y     = value_y_q;
	assign status      = status_q;
	assign points_held = points_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pli_pkg::CNT_FULL)
		else $error("point count beyond table size");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_ctl.busy)
		else $error("divider restarted while busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != pli_pkg::ST_OK)) |-> (value_y == '0))
		else $error("nonzero value with error status");

endmodule
